// ===== sv/cmvd_pkg.sv =====
`default_nettype none
package cmvd_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int MAX_SUB_DEF    = 64;

    localparam int WS_W   = 9;   // window length register
    localparam int TH_W   = 32;  // motion_threshold register
    localparam int CFG_W  = 32;
    localparam int AMP_W  = 16;
    localparam int VAR_W  = 32;
    localparam int CNT32_W = 32;
    localparam int DEN_W  = 2 * WS_W;

    localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;
    localparam logic [0:0] REG_THRESHOLD   = 1'b1;

    typedef enum logic {
        OP_SQRT = 1'b0,
        OP_DIV  = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_iter_cmd;

endpackage
`default_nettype wire

// ===== sv/cmvd_ram.sv =====
`default_nettype none
module cmvd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== sv/cmvd_iter.sv =====
`default_nettype none
module cmvd_iter #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 18
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire cmvd_pkg::t_iter_cmd i_cmd,
    input  wire logic [NUM_W-1:0]    i_num,
    input  wire logic [DEN_W-1:0]    i_den,
    output logic                     o_done,
    output logic [NUM_W-1:0]         o_result
);
    import cmvd_pkg::*;

    localparam int HALF_W = NUM_W / 2;
    localparam int REM_W  = (HALF_W + 3 > DEN_W + 2) ? HALF_W + 3 : DEN_W + 2;
    localparam int CNT_W  = $clog2(NUM_W + 1);

    logic             r_busy;
    t_op              r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_acc;
    logic [REM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_res;
    logic [DEN_W-1:0] r_den;
    logic             r_done;

    logic [REM_W-1:0] w_shift;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    // shift-subtract step: one quotient bit, or one root bit per two radicand bits
    always_comb begin
        if (r_op == OP_DIV) begin
            w_shift = {r_rem[REM_W-2:0], r_acc[NUM_W-1]};
            w_trial = REM_W'(r_den);
        end else begin
            w_shift = {r_rem[REM_W-3:0], r_acc[NUM_W-1:NUM_W-2]};
            w_trial = REM_W'({r_res[HALF_W-1:0], 2'b01});
        end
        w_ge = (w_shift >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= w_ge ? (w_shift - w_trial) : w_shift;
                r_res <= {r_res[NUM_W-2:0], w_ge};
                r_acc <= (r_op == OP_DIV) ? {r_acc[NUM_W-2:0], 1'b0}
                                          : {r_acc[NUM_W-3:0], 2'b00};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_op   <= i_cmd.op;
                r_acc  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_res  <= '0;
                r_cnt  <= (i_cmd.op == OP_DIV) ? CNT_W'(NUM_W) : CNT_W'(HALF_W);
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;
endmodule
`default_nettype wire

// ===== sv/csi_motion_variance_detector_core.sv =====
`default_nettype none
// Motion detector on CSI subcarriers. One subcarrier is taken per beat; the input
// stalls while it is worked on. An unselected, non-last subcarrier is taken without
// a stall; a selected one stalls the input for its amplitude square root. The last
// subcarrier of a packet adds, when any amplitude was counted, a square root and a
// divide by the amplitude count and, once the window is full, a divide by the window
// length squared, and it waits while the output register holds a result not yet taken.
// All square roots and divides run on one shared shift-subtract unit producing one
// result bit per cycle.
// One result beat per packet leaves through an output register, so a new subcarrier
// is taken while the result still waits.
module csi_motion_variance_detector_core #(
    parameter int MAX_WINDOW      = cmvd_pkg::MAX_WINDOW_DEF,
    parameter int MAX_SUBCARRIERS = cmvd_pkg::MAX_SUB_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [0:0]                    i_cfg_index,
    input  wire logic [cmvd_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic signed [7:0]             i_i_value,
    input  wire logic signed [7:0]             i_q_value,
    input  wire logic                          i_selected,
    input  wire logic                          i_last_subcarrier,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [cmvd_pkg::AMP_W-1:0]         o_turbulence,
    output logic [cmvd_pkg::VAR_W-1:0]         o_moving_variance,
    output logic                               o_motion,
    output logic                               o_window_full,
    output logic [cmvd_pkg::CNT32_W-1:0]       o_packet_count
);
    import cmvd_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SUBCARRIERS + 1);
    localparam int ASUM_W  = AMP_W + CNT_W;
    localparam int ASQ_W   = 2 * AMP_W + CNT_W;
    localparam int TNUM_W  = CNT_W + ASQ_W;
    localparam int WIDX_W  = $clog2(MAX_WINDOW);
    localparam int FILL_W  = $clog2(MAX_WINDOW + 1);
    localparam int WSUM_W  = AMP_W + FILL_W;
    localparam int WSQ_W   = 2 * AMP_W + FILL_W;
    localparam int VNUM_W  = WS_W + WSQ_W;
    localparam int RAW_W   = (TNUM_W > VNUM_W) ? TNUM_W : VNUM_W;
    localparam int NUM_W   = RAW_W + (RAW_W % 2);
    localparam int CMP_W   = ((FILL_W > WS_W) ? FILL_W : WS_W) + 2;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_AMP  = 12'b000000000010,
        S_TMUL = 12'b000000000100,
        S_TSUB = 12'b000000001000,
        S_TSQ  = 12'b000000010000,
        S_TDIV = 12'b000000100000,
        S_WIN  = 12'b000001000000,
        S_UPD  = 12'b000010000000,
        S_VMUL = 12'b000100000000,
        S_VSUB = 12'b001000000000,
        S_VDIV = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;

    t_state            r_state;
    logic [WS_W-1:0]   r_size;
    logic [TH_W-1:0]   r_thresh;
    logic              r_last;
    logic [ASUM_W-1:0] r_asum;
    logic [ASQ_W-1:0]  r_asq;
    logic [CNT_W-1:0]  r_acnt;
    logic [WIDX_W-1:0] r_pos;
    logic [FILL_W-1:0] r_fill;
    logic [WSUM_W-1:0] r_wsum;
    logic [WSQ_W-1:0]  r_wsq;
    logic              r_full_before;
    logic              r_motion;
    logic [CNT32_W-1:0] r_packets;
    logic [NUM_W-1:0]  r_p1;
    logic [NUM_W-1:0]  r_p2;
    logic [DEN_W-1:0]  r_den;
    logic [AMP_W-1:0]  r_turb;
    logic [VAR_W-1:0]  r_var;
    logic              r_out_valid;
    logic [AMP_W-1:0]  r_o_turb;
    logic [VAR_W-1:0]  r_o_var;
    logic              r_o_motion;
    logic              r_o_full;
    logic [CNT32_W-1:0] r_o_packets;

    t_iter_cmd         w_cmd;
    logic [NUM_W-1:0]  w_num;
    logic [DEN_W-1:0]  w_den;
    logic              w_done;
    logic [NUM_W-1:0]  w_res;
    logic              w_in_acc;
    logic              w_use_amp;
    logic [15:0]       w_power;
    logic [AMP_W-1:0]  w_ram_rd;
    logic              w_ram_we;
    logic [WIDX_W-1:0] w_pos_wr;
    logic [WS_W-1:0]   w_new_size;
    logic              w_full_now;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_use_amp  = i_selected && (CMP_W'(r_acnt) < CMP_W'(MAX_SUBCARRIERS));
    assign w_power    = 16'(i_i_value * i_i_value) + 16'(i_q_value * i_q_value);
    assign w_full_now = (CMP_W'(r_fill) >= CMP_W'(r_size));
    assign w_pos_wr   = (CMP_W'(r_pos) >= CMP_W'(r_size)) ? '0 : r_pos;

    // feed the shared unit
    always_comb begin
        w_cmd = '{start: 1'b0, op: OP_SQRT};
        w_num = '0;
        w_den = '0;
        unique case (r_state)
            S_IDLE: begin
                w_cmd = '{start: w_in_acc && w_use_amp, op: OP_SQRT};
                w_num = NUM_W'({w_power, 16'h0000});
            end
            S_TSUB: begin
                w_cmd = '{start: 1'b1, op: OP_SQRT};
                w_num = r_p1 - r_p2;
            end
            S_TSQ: begin
                w_cmd = '{start: w_done, op: OP_DIV};
                w_num = NUM_W'(w_res[NUM_W/2-1:0]);
                w_den = DEN_W'(r_acnt);
            end
            S_VSUB: begin
                w_cmd = '{start: 1'b1, op: OP_DIV};
                w_num = r_p1 - r_p2;
                w_den = r_den;
            end
            default: begin
            end
        endcase
    end

    cmvd_iter #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_iter (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_num    (w_num),
        .i_den    (w_den),
        .o_done   (w_done),
        .o_result (w_res)
    );

    assign w_ram_we = (r_state == S_UPD);

    cmvd_ram #(
        .WIDTH (AMP_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_turb),
        .i_raddr (w_pos_wr),
        .o_rdata (w_ram_rd)
    );

    assign w_new_size = i_cfg_data[WS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_size      <= WS_W'(50);
            r_thresh    <= TH_W'(65536);
            r_asum      <= '0;
            r_asq       <= '0;
            r_acnt      <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_wsum      <= '0;
            r_wsq       <= '0;
            r_motion    <= 1'b0;
            r_packets   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: loads from S_OUT, empties when the beat is taken
            if (r_state == S_OUT && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_last <= i_last_subcarrier;
                        if (w_use_amp) begin
                            r_state <= S_AMP;
                        end else if (i_last_subcarrier) begin
                            r_state <= S_TMUL;
                        end
                    end
                end
                S_AMP: begin
                    if (w_done) begin
                        r_asum  <= r_asum + ASUM_W'(w_res[AMP_W-1:0]);
                        r_asq   <= r_asq + ASQ_W'(w_res[AMP_W-1:0] * w_res[AMP_W-1:0]);
                        r_acnt  <= r_acnt + 1'b1;
                        r_state <= r_last ? S_TMUL : S_IDLE;
                    end
                end
                S_TMUL: begin
                    if (r_acnt == '0) begin
                        r_turb  <= '0;
                        r_state <= S_WIN;
                    end else begin
                        r_p1    <= NUM_W'(r_acnt * r_asq);
                        r_p2    <= NUM_W'(r_asum * r_asum);
                        r_state <= S_TSUB;
                    end
                end
                S_TSUB: r_state <= S_TSQ;
                S_TSQ: begin
                    if (w_done) begin
                        r_state <= S_TDIV;
                    end
                end
                S_TDIV: begin
                    if (w_done) begin
                        r_turb  <= (|w_res[NUM_W-1:AMP_W]) ? '1 : w_res[AMP_W-1:0];
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    // position wraps before use; ram read of the evicted entry issued here
                    r_asum        <= '0;
                    r_asq         <= '0;
                    r_acnt        <= '0;
                    r_pos         <= w_pos_wr;
                    r_full_before <= w_full_now;
                    r_state       <= S_UPD;
                end
                S_UPD: begin
                    if (r_full_before) begin
                        r_wsum <= r_wsum - WSUM_W'(w_ram_rd) + WSUM_W'(r_turb);
                        r_wsq  <= r_wsq - WSQ_W'(w_ram_rd * w_ram_rd)
                                        + WSQ_W'(r_turb * r_turb);
                        r_fill <= FILL_W'(r_size);
                    end else begin
                        r_wsum <= r_wsum + WSUM_W'(r_turb);
                        r_wsq  <= r_wsq + WSQ_W'(r_turb * r_turb);
                        r_fill <= r_fill + 1'b1;
                    end
                    r_pos   <= (CMP_W'(r_pos) + CMP_W'(1) >= CMP_W'(r_size)) ? '0
                                                                          : r_pos + 1'b1;
                    r_state <= S_VMUL;
                end
                S_VMUL: begin
                    if (w_full_now) begin
                        r_p1    <= NUM_W'(r_size * r_wsq);
                        r_p2    <= NUM_W'(r_wsum * r_wsum);
                        r_den   <= r_size * r_size;
                        r_state <= S_VSUB;
                    end else begin
                        r_var   <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_VSUB: r_state <= S_VDIV;
                S_VDIV: begin
                    if (w_done) begin
                        r_var   <= (|w_res[NUM_W-1:VAR_W]) ? '1 : w_res[VAR_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_o_turb    <= r_turb;
                        r_o_var     <= r_var;
                        r_o_full    <= w_full_now;
                        r_o_packets <= r_packets + 1'b1;
                        r_packets   <= r_packets + 1'b1;
                        // hysteresis: equal to threshold keeps the state
                        if (!r_motion && r_var > r_thresh) begin
                            r_motion   <= 1'b1;
                            r_o_motion <= 1'b1;
                        end else if (r_motion && r_var < r_thresh) begin
                            r_motion   <= 1'b0;
                            r_o_motion <= 1'b0;
                        end else begin
                            r_o_motion <= r_motion;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_WINDOW_SIZE: begin
                        if (w_new_size >= WS_W'(2)
                            && CMP_W'(w_new_size) <= CMP_W'(MAX_WINDOW)
                            && w_new_size != r_size) begin
                            r_size <= w_new_size;
                            r_pos  <= '0;
                            r_fill <= '0;
                            r_wsum <= '0;
                            r_wsq  <= '0;
                        end
                    end
                    REG_THRESHOLD: r_thresh <= i_cfg_data[TH_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_turbulence      = r_o_turb;
    assign o_moving_variance = r_o_var;
    assign o_motion          = r_o_motion;
    assign o_window_full     = r_o_full;
    assign o_packet_count    = r_o_packets;

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> (r_state == S_AMP || r_state == S_TSQ || r_state == S_TDIV
                    || r_state == S_VDIV))
        else $error("shared unit finished outside a wait state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_fill) <= CMP_W'(r_size))
        else $error("window fill above window size");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (CMP_W'(r_pos) < CMP_W'(r_size)))
        else $error("window position out of range");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_acnt) <= CMP_W'(MAX_SUBCARRIERS))
        else $error("amplitude count above limit");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_out_valid || !i_out_stall)) |=> r_state == S_IDLE)
        else $error("result issued without returning to idle");
endmodule
`default_nettype wire
